>>> rtl/sjf_nonpreemptive_scheduler_core_assert.svh
// ----------------------------------------------------------------------------
// scheduler assertion macros
// shared concurrent assertion forms for the job scheduler rtl
// ----------------------------------------------------------------------------
`ifndef SJF_NONPREEMPTIVE_SCHEDULER_CORE_ASSERT_SVH
`define SJF_NONPREEMPTIVE_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication
`define SJF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// next-cycle implication
`define SJF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

>>> rtl/sjfns_pkg.sv
// ----------------------------------------------------------------------------
// sjfns_pkg
// shared constants and types of the shortest-job-first scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package sjfns_pkg;

  localparam int MAX_JOBS = 16;
  localparam int SLOT_W   = $clog2(MAX_JOBS);
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int NEED_W   = 8;
  localparam int TIME_W   = 16;

  // job status codes
  localparam logic [1:0] JS_EMPTY = 2'd0;
  localparam logic [1:0] JS_WAIT  = 2'd1;
  localparam logic [1:0] JS_RUN   = 2'd2;
  localparam logic [1:0] JS_FIN   = 2'd3;

  // command codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // cell operations
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_RUN  = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [SLOT_W-1:0] slot;
    logic [NEED_W-1:0] need;
    logic [TIME_W-1:0] arrival;
  } ctl_t;

  typedef struct packed {
    logic              vld;
    logic              have;
    logic [SLOT_W-1:0] pick;
    logic [NEED_W-1:0] best;
  } wave_t;

endpackage

`default_nettype wire

>>> rtl/sjfns_cell.sv
// ----------------------------------------------------------------------------
// sjfns_cell
// one job slot: holds need, arrival and status, and refines the search wave
// ----------------------------------------------------------------------------
`default_nettype none

module sjfns_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [sjfns_pkg::SLOT_W-1:0]  idx_i,
  input  wire sjfns_pkg::ctl_t               ctl_i,
  input  wire logic [sjfns_pkg::TIME_W-1:0]  now_i,
  input  wire sjfns_pkg::wave_t              wave_i,
  output sjfns_pkg::wave_t                   wave_o
);
  import sjfns_pkg::*;

  logic [1:0]        status_r;
  logic [1:0]        status_nxt;
  logic [NEED_W-1:0] need_r;
  logic [NEED_W-1:0] need_nxt;
  logic [TIME_W-1:0] arr_r;
  logic [TIME_W-1:0] arr_nxt;
  logic              vld_r;
  wave_t             wave_r;
  logic              hit;
  logic              elig;
  logic              take;
  logic [NEED_W-1:0] need_dec;

  assign hit      = (ctl_i.slot == idx_i);
  assign need_dec = need_r - NEED_W'(1);

  always_comb begin
    status_nxt = status_r;
    need_nxt   = need_r;
    arr_nxt    = arr_r;
    if (hit) begin
      case (ctl_i.op)
        OP_ADD: begin
          need_nxt   = ctl_i.need;
          arr_nxt    = ctl_i.arrival;
          status_nxt = (ctl_i.need == '0) ? JS_FIN : JS_WAIT;
        end
        OP_RUN: begin
          need_nxt   = need_dec;
          status_nxt = (need_dec == '0) ? JS_FIN : JS_RUN;
        end
        default: begin
        end
      endcase
    end
  end

  assign elig = (status_r == JS_WAIT) && (arr_r <= now_i);
  assign take = wave_i.vld && elig && (!wave_i.have || (need_r <= wave_i.best));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= JS_EMPTY;
      vld_r    <= 1'b0;
    end else begin
      status_r <= status_nxt;
      vld_r    <= wave_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    need_r      <= need_nxt;
    arr_r       <= arr_nxt;
    wave_r.vld  <= 1'b0;
    wave_r.have <= wave_i.have | take;
    wave_r.pick <= take ? idx_i : wave_i.pick;
    wave_r.best <= take ? need_r : wave_i.best;
  end

  always_comb begin
    wave_o     = wave_r;
    wave_o.vld = vld_r;
  end

endmodule

`default_nettype wire

>>> rtl/sjf_nonpreemptive_scheduler_core.sv
// ----------------------------------------------------------------------------
// sjf_nonpreemptive_scheduler_core
// non-preemptive shortest-job-first job table with arrival times
// ----------------------------------------------------------------------------
// An add beat completes in the cycle it is accepted, as does a tick while a
// job holds the processor. A tick that must choose a new job sends a search
// wave down the row of sixteen cells, one cell per cycle; busy is high during
// the search. Every beat gives exactly one result, shown on the out_ ports for
// one cycle with out_strobe high the cycle after the beat completes; the
// receiver cannot stall, so the result must be captured in that cycle.
`default_nettype none
`include "sjf_nonpreemptive_scheduler_core_assert.svh"

module sjf_nonpreemptive_scheduler_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_cmd,
  input  wire logic [sjfns_pkg::TIME_W-1:0]  in_arrival_time,
  input  wire logic [sjfns_pkg::NEED_W-1:0]  in_need_time,
  output logic                               out_strobe,
  output logic                               out_accepted,
  output logic [3:0]                         out_slot,
  output logic                               out_idle,
  output logic                               out_job_finished,
  output logic [sjfns_pkg::NEED_W-1:0]       out_remaining,
  output logic                               out_all_done,
  output logic [sjfns_pkg::TIME_W-1:0]       out_now
);
  import sjfns_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic              state_r, state_nxt;
  logic [CNT_W-1:0]  job_cnt_r, job_cnt_nxt;
  logic [CNT_W-1:0]  fin_cnt_r, fin_cnt_nxt;
  logic              run_vld_r, run_vld_nxt;
  logic [SLOT_W-1:0] run_slot_r, run_slot_nxt;
  logic [NEED_W-1:0] cur_need_r, cur_need_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;

  logic              strobe_r;
  logic              acc_r, idle_r, fin_r, done_r;
  logic [3:0]        slot_r;
  logic [NEED_W-1:0] rem_r;
  logic [TIME_W-1:0] now_r;

  logic              accept, fire, launch;
  logic              t_go, t_have;
  logic [SLOT_W-1:0] t_pick;
  logic [NEED_W-1:0] t_need, t_rem;
  logic              o_acc, o_idle, o_fin;
  logic [3:0]        o_slot;
  logic [NEED_W-1:0] o_rem;
  ctl_t              ctl;
  wave_t             wave [MAX_JOBS+1];

  assign busy   = (state_r == S_SCAN);
  assign accept = start && !busy;
  assign t_rem  = t_need - NEED_W'(1);

  always_comb begin
    state_nxt    = state_r;
    job_cnt_nxt  = job_cnt_r;
    fin_cnt_nxt  = fin_cnt_r;
    run_vld_nxt  = run_vld_r;
    run_slot_nxt = run_slot_r;
    cur_need_nxt = cur_need_r;
    time_nxt     = time_r;
    ctl          = '0;
    fire         = 1'b0;
    launch       = 1'b0;
    t_go         = 1'b0;
    t_have       = 1'b0;
    t_pick       = '0;
    t_need       = '0;
    o_acc        = 1'b0;
    o_idle       = 1'b0;
    o_fin        = 1'b0;
    o_slot       = '0;
    o_rem        = '0;

    if (accept && in_cmd == CMD_ADD) begin
      fire = 1'b1;
      if (job_cnt_r < CNT_W'(MAX_JOBS)) begin
        ctl.op      = OP_ADD;
        ctl.slot    = job_cnt_r[SLOT_W-1:0];
        ctl.need    = in_need_time;
        ctl.arrival = in_arrival_time;
        job_cnt_nxt = job_cnt_r + CNT_W'(1);
        if (in_need_time == '0) begin
          fin_cnt_nxt = fin_cnt_r + CNT_W'(1);
        end
        o_acc  = 1'b1;
        o_slot = 4'(job_cnt_r[SLOT_W-1:0]);
        o_rem  = in_need_time;
      end
    end

    if (accept && in_cmd == CMD_TICK) begin
      if (run_vld_r) begin
        t_go   = 1'b1;
        t_have = 1'b1;
        t_pick = run_slot_r;
        t_need = cur_need_r;
      end else begin
        launch    = 1'b1;
        state_nxt = S_SCAN;
      end
    end

    if (state_r == S_SCAN && wave[MAX_JOBS].vld) begin
      t_go      = 1'b1;
      t_have    = wave[MAX_JOBS].have;
      t_pick    = wave[MAX_JOBS].pick;
      t_need    = wave[MAX_JOBS].best;
      state_nxt = S_IDLE;
    end

    if (t_go) begin
      fire = 1'b1;
      if (time_r != '1) begin
        time_nxt = time_r + TIME_W'(1);
      end
      if (t_have) begin
        ctl.op       = OP_RUN;
        ctl.slot     = t_pick;
        o_slot       = 4'(t_pick);
        o_rem        = t_rem;
        o_fin        = (t_rem == '0);
        run_vld_nxt  = (t_rem != '0);
        run_slot_nxt = t_pick;
        cur_need_nxt = t_rem;
        if (t_rem == '0) begin
          fin_cnt_nxt = fin_cnt_r + CNT_W'(1);
        end
      end else begin
        o_idle      = 1'b1;
        run_vld_nxt = 1'b0;
      end
    end
  end

  // search wave enters the first cell
  always_comb begin
    wave[0]      = '0;
    wave[0].vld  = launch;
  end

  for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
    sjfns_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .idx_i  (SLOT_W'(g)),
      .ctl_i  (ctl),
      .now_i  (time_r),
      .wave_i (wave[g]),
      .wave_o (wave[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      job_cnt_r  <= '0;
      fin_cnt_r  <= '0;
      run_vld_r  <= 1'b0;
      run_slot_r <= '0;
      time_r     <= '0;
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      job_cnt_r  <= job_cnt_nxt;
      fin_cnt_r  <= fin_cnt_nxt;
      run_vld_r  <= run_vld_nxt;
      run_slot_r <= run_slot_nxt;
      time_r     <= time_nxt;
      strobe_r   <= fire;
    end
  end

  always_ff @(posedge clk) begin
    cur_need_r <= cur_need_nxt;
    acc_r      <= o_acc;
    slot_r     <= o_slot;
    idle_r     <= o_idle;
    fin_r      <= o_fin;
    rem_r      <= o_rem;
    done_r     <= (fin_cnt_nxt == job_cnt_nxt);
    now_r      <= time_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_accepted     = acc_r;
  assign out_slot         = slot_r;
  assign out_idle         = idle_r;
  assign out_job_finished = fin_r;
  assign out_remaining    = rem_r;
  assign out_all_done     = done_r;
  assign out_now          = now_r;

  `SJF_ASSERT_NEXT(a_scan_entry, accept && in_cmd == CMD_TICK && !run_vld_r, busy)
  `SJF_ASSERT_NOW(a_fin_le_cnt, 1'b1, fin_cnt_r <= job_cnt_r)
  `SJF_ASSERT_NOW(a_run_stored, run_vld_r, CNT_W'(run_slot_r) < job_cnt_r)
  `SJF_ASSERT_NOW(a_no_result_in_scan, state_r == S_SCAN, !strobe_r)

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the shortest-job-first scheduler core
// ----------------------------------------------------------------------------
// A short table of add and tick commands comes first. It covers an empty
// tick, a zero-need job, the extreme arrival and need, a tie on need, and a
// short job that arrives while another job runs. Random add and tick
// commands follow, and the job table is then filled until adds are refused.
// A bounded run of ticks then works down the jobs still pending. An in-bench
// scheduler model predicts each result, or the table row gives it, and every
// strobed result is compared against that prediction in order.
// ----------------------------------------------------------------------------

module tb;
  import sjfns_pkg::*;

  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int RANDOM_BEATS = 1600;
  localparam int TAIL_TICKS   = 40;

  typedef struct packed {
    logic              accepted;
    logic [3:0]        slot;
    logic              idle;
    logic              fin;
    logic [NEED_W-1:0] rem;
    logic              all_done;
    logic [TIME_W-1:0] now;
  } sched_res_t;

  typedef struct {
    logic              cmd;
    logic [TIME_W-1:0] arr;
    logic [NEED_W-1:0] need;
    bit                typed;
    sched_res_t        res;
  } plan_row_t;

  logic              clk;
  logic              rst_n           = 1'b0;
  logic              start           = 1'b0;
  logic              in_cmd          = CMD_ADD;
  logic [TIME_W-1:0] in_arrival_time = '0;
  logic [NEED_W-1:0] in_need_time    = '0;
  logic              busy;
  logic              out_strobe;
  logic              out_accepted;
  logic [3:0]        out_slot;
  logic              out_idle;
  logic              out_job_finished;
  logic [NEED_W-1:0] out_remaining;
  logic              out_all_done;
  logic [TIME_W-1:0] out_now;

  // scheduler model state
  logic [NEED_W-1:0] need_left [MAX_JOBS];
  logic [TIME_W-1:0] ready_at  [MAX_JOBS];
  logic [1:0]        job_st    [MAX_JOBS];
  int                n_jobs;
  int                run_slot;
  bit                run_valid;
  logic [TIME_W-1:0] tick_now;

  sched_res_t res_q [$];
  plan_row_t  plan_q [$];
  bit         gaps_on = 1'b1;
  int         n_bad, n_checked, n_sent, n_idle, n_refused;

  sjf_nonpreemptive_scheduler_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_arrival_time  (in_arrival_time),
    .in_need_time     (in_need_time),
    .out_strobe       (out_strobe),
    .out_accepted     (out_accepted),
    .out_slot         (out_slot),
    .out_idle         (out_idle),
    .out_job_finished (out_job_finished),
    .out_remaining    (out_remaining),
    .out_all_done     (out_all_done),
    .out_now          (out_now)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic bit jobs_all_done();
    int i;
    for (i = 0; i < n_jobs; i++) begin
      if (job_st[i] != JS_FIN) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic sched_res_t sched_step(logic cmd, logic [TIME_W-1:0] arr,
                                            logic [NEED_W-1:0] need);
    sched_res_t        r;
    bit                have;
    int                pick;
    int                i;
    logic [NEED_W-1:0] best;
    r    = '0;
    have = 1'b0;
    pick = 0;
    best = '0;
    if (cmd == CMD_ADD) begin
      if (n_jobs < MAX_JOBS) begin
        need_left[n_jobs] = need;
        ready_at[n_jobs]  = arr;
        job_st[n_jobs]    = (need == 0) ? JS_FIN : JS_WAIT;
        r.accepted        = 1'b1;
        r.slot            = 4'(n_jobs);
        r.rem             = need;
        n_jobs++;
      end
    end else begin
      if (run_valid && run_slot < n_jobs) begin
        have = 1'b1;
        pick = run_slot;
      end else begin
        run_valid = 1'b0;
        // ties go to the later slot
        for (i = 0; i < n_jobs; i++) begin
          if (job_st[i] == JS_WAIT && ready_at[i] <= tick_now &&
              (!have || need_left[i] <= best)) begin
            have = 1'b1;
            pick = i;
            best = need_left[i];
          end
        end
      end
      if (tick_now != '1) tick_now++;
      if (!have) begin
        r.idle = 1'b1;
      end else begin
        if (need_left[pick] != 0) need_left[pick]--;
        r.slot = 4'(pick);
        r.rem  = need_left[pick];
        if (need_left[pick] == 0) begin
          job_st[pick] = JS_FIN;
          run_valid    = 1'b0;
          r.fin        = 1'b1;
        end else begin
          job_st[pick] = JS_RUN;
          run_valid    = 1'b1;
          run_slot     = pick;
        end
      end
    end
    r.all_done = jobs_all_done();
    r.now      = tick_now;
    return r;
  endfunction

  function automatic sched_res_t res_of(bit acc, int slot, bit idl, bit fin, int rem,
                                        bit done, int tnow);
    return {acc, 4'(slot), idl, fin, NEED_W'(rem), done, TIME_W'(tnow)};
  endfunction

  function automatic logic [TIME_W-1:0] pick_arrival();
    int a;
    if ($urandom_range(9) < 7) begin
      a = int'(tick_now) + $urandom_range(0, 30);
      if (a > 65535) a = 65535;
      return TIME_W'(a);
    end
    return TIME_W'($urandom);
  endfunction

  function automatic logic [NEED_W-1:0] pick_need();
    int v;
    v = $urandom_range(99);
    if (v < 60) return NEED_W'($urandom_range(1, 6));
    if (v < 85) return NEED_W'($urandom_range(1, 40));
    return NEED_W'($urandom_range(1, 255));
  endfunction

  task automatic plan_row(logic cmd, int arr, int need, bit typed, sched_res_t res);
    plan_row_t p;
    p.cmd   = cmd;
    p.arr   = TIME_W'(arr);
    p.need  = NEED_W'(need);
    p.typed = typed;
    p.res   = res;
    plan_q.push_back(p);
  endtask

  // one beat per call: drive at the falling edge, wait for the accepting edge
  task automatic send_item(logic cmd, logic [TIME_W-1:0] arr, logic [NEED_W-1:0] need,
                           bit typed, sched_res_t typed_res);
    sched_res_t r;
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 11) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start           <= 1'b1;
    in_cmd          <= cmd;
    in_arrival_time <= arr;
    in_need_time    <= need;
    do @(posedge clk); while (busy);
    r = sched_step(cmd, arr, need);
    res_q.push_back(typed ? typed_res : r);
    n_sent++;
    if (r.idle) n_idle++;
    if (cmd == CMD_ADD && !r.accepted) n_refused++;
  endtask

  always @(posedge clk) begin : result_check
    sched_res_t got;
    sched_res_t want;
    if (rst_n && out_strobe) begin
      got = {out_accepted, out_slot, out_idle, out_job_finished, out_remaining,
             out_all_done, out_now};
      n_checked++;
      if (res_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result at cycle time %0t", $realtime);
      end else begin
        want = res_q.pop_front();
        if (got !== want) begin
          n_bad++;
          if (n_bad <= 10)
            $display({"mismatch: acc/slot/idle/fin/rem/done/now exp ",
                      "%0d/%0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d/%0d"},
                     want.accepted, want.slot, want.idle, want.fin, want.rem,
                     want.all_done, want.now, got.accepted, got.slot, got.idle,
                     got.fin, got.rem, got.all_done, got.now);
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t         p;
    int                n_rand;
    int                v;
    bit                full;
    logic              cmd_r;
    logic [TIME_W-1:0] arr_r;
    logic [NEED_W-1:0] need_r;

    for (v = 0; v < MAX_JOBS; v++) job_st[v] = JS_EMPTY;
    n_jobs    = 0;
    run_slot  = 0;
    run_valid = 1'b0;
    tick_now  = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    //       cmd       arrival need  typed  expected
    plan_row(CMD_TICK, 0,      0,    1'b1,  res_of(0, 0, 1, 0, 0,   1, 1));
    plan_row(CMD_ADD,  0,      0,    1'b1,  res_of(1, 0, 0, 0, 0,   1, 1));
    plan_row(CMD_ADD,  65535,  255,  1'b1,  res_of(1, 1, 0, 0, 255, 0, 1));
    plan_row(CMD_TICK, 0,      0,    1'b1,  res_of(0, 0, 1, 0, 0,   0, 2));
    plan_row(CMD_ADD,  0,      3,    1'b0,  '0);
    plan_row(CMD_ADD,  0,      3,    1'b0,  '0);
    plan_row(CMD_ADD,  1,      5,    1'b0,  '0);
    plan_row(CMD_TICK, 0,      0,    1'b0,  '0);
    plan_row(CMD_ADD,  2,      1,    1'b0,  '0);
    plan_row(CMD_TICK, 65535,  255,  1'b0,  '0);
    plan_row(CMD_TICK, 0,      0,    1'b0,  '0);
    plan_row(CMD_TICK, 0,      0,    1'b0,  '0);
    plan_row(CMD_ADD,  40,     2,    1'b0,  '0);
    for (v = 0; v < 8; v++) plan_row(CMD_TICK, v * 4099, v * 31, 1'b0, '0);
    plan_row(CMD_TICK, 0,      0,    1'b0,  '0);
    plan_row(CMD_TICK, 0,      0,    1'b0,  '0);

    foreach (plan_q[k]) begin
      p = plan_q[k];
      send_item(p.cmd, p.arr, p.need, p.typed, p.res);
    end

    n_rand = 0;
    while (n_rand < RANDOM_BEATS) begin
      gaps_on = !(n_rand >= 500 && n_rand < 800);
      v       = $urandom_range(99);
      full    = (n_jobs >= MAX_JOBS);
      if ((!full && v < 2) || (full && v < 8)) begin
        cmd_r  = CMD_ADD;
        arr_r  = pick_arrival();
        need_r = pick_need();
      end else begin
        cmd_r  = CMD_TICK;
        arr_r  = TIME_W'($urandom);
        need_r = NEED_W'($urandom);
      end
      send_item(cmd_r, arr_r, need_r, 1'b0, '0);
      n_rand++;
    end
    gaps_on = 1'b1;

    // fill the table, then push past it
    while (n_jobs < MAX_JOBS) send_item(CMD_ADD, pick_arrival(), pick_need(), 1'b0, '0);
    repeat (3) send_item(CMD_ADD, TIME_W'($urandom), pick_need(), 1'b0, '0);

    // work down pending jobs for a bounded stretch
    v = 0;
    while (!jobs_all_done() && v < TAIL_TICKS) begin
      send_item(CMD_TICK, TIME_W'($urandom), NEED_W'($urandom), 1'b0, '0);
      v++;
    end
    repeat (6) send_item(CMD_TICK, TIME_W'($urandom), NEED_W'($urandom), 1'b0, '0);

    @(negedge clk);
    start <= 1'b0;
    while (res_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("run covered %0d commands, %0d results checked, %0d idle ticks, %0d adds refused",
             n_sent, n_checked, n_idle, n_refused);
    $display("clock ended at %0d with %0d jobs stored, %0d mismatches",
             tick_now, n_jobs, n_bad);
    if (n_bad == 0 && res_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
